### rtl/core/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared command and status types for the controller and the datapath, and the controller's state encoding.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  typedef struct packed {
    logic clear;
    logic start;
    logic step;
    logic commit;
  } lrukv_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lrukv_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_OUT    = 4'b1000
  } lrukv_state_t;

endpackage

### rtl/core/lrukv_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Sequences configuration and request acceptance, the entry scan, the commit and the result.
// ----------------------------------------------------------------------------
module lrukv_ctrl import lrukv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  lrukv_sts_t sts,
  output lrukv_cmd_t cmd
);

  lrukv_state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.clear = cfg_valid && cfg_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### rtl/core/lrukv_dp.sv
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Key and value memories, valid and rank registers, scan and update logic.
// ----------------------------------------------------------------------------
module lrukv_dp import lrukv_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lrukv_cmd_t        cmd,
  output lrukv_sts_t        sts,
  input  logic [4:0]        cfg_data,
  input  logic              in_req_type,
  input  logic [31:0]       in_lookup_key,
  input  logic signed [31:0] in_write_value,
  output logic              out_found,
  output logic signed [31:0] out_read_value,
  output logic              out_evicted,
  output logic [31:0]       out_evicted_key
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [31:0]         val_mem [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [IW-1:0]       rank_r [ENTRIES];
  logic [CW-1:0]       occ_r;
  logic [4:0]          cap_r;

  logic                put_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0]         wval_r;
  logic [CW-1:0]       idx_r;
  logic                rd_pend_r;
  logic [IW-1:0]       rd_idx_r;
  logic [KEY_BITS-1:0] rd_key_r;
  logic [31:0]         rd_val_r;
  logic                hit_r;
  logic [IW-1:0]       hit_idx_r;
  logic [31:0]         hit_val_r;
  logic                lru_ok_r;
  logic [IW-1:0]       lru_idx_r;
  logic [KEY_BITS-1:0] lru_key_r;
  logic                free_ok_r;
  logic [IW-1:0]       free_idx_r;

  logic                found_r, evicted_r;
  logic [31:0]         rval_r, evkey_r;

  logic [CW-1:0] cap_eff;
  logic          rd_match;
  logic          rd_lru;
  logic          do_ins, do_evict;
  logic [IW-1:0] slot;
  logic [IW-1:0] limit;
  logic          limit_all;
  logic [KEY_BITS-1:0] key_in;

  assign key_in  = KEY_BITS'(in_lookup_key);
  assign cap_eff = (int'(cap_r) > ENTRIES) ? CW'(ENTRIES) : CW'(cap_r);
  assign rd_match = rd_pend_r && valid_r[rd_idx_r] && (rd_key_r == key_r);
  assign rd_lru   = rd_pend_r && valid_r[rd_idx_r] && (CW'(rank_r[rd_idx_r]) == occ_r - 1'b1);
  assign sts.scan_done = !rd_pend_r && (idx_r == CW'(ENTRIES));

  assign do_ins   = put_r && !hit_r && (cap_eff != '0);
  assign do_evict = do_ins && (occ_r >= cap_eff);
  assign slot     = hit_r ? hit_idx_r : (do_evict ? lru_idx_r : free_idx_r);
  assign limit    = rank_r[hit_idx_r];
  assign limit_all = !hit_r;

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[IW'(idx_r)];
    rd_val_r <= val_mem[IW'(idx_r)];
    if (cmd.start) begin
      put_r  <= in_req_type;
      key_r  <= key_in;
      wval_r <= in_write_value;
    end
    if (cmd.commit && (do_ins || (hit_r && put_r))) begin
      key_mem[slot] <= key_r;
      val_mem[slot] <= wval_r;
    end
    if (cmd.commit) begin
      found_r   <= hit_r;
      rval_r    <= (hit_r && !put_r) ? hit_val_r : 32'd0;
      evicted_r <= put_r && !hit_r && (do_evict || cap_eff == '0);
      evkey_r   <= !(put_r && !hit_r) ? 32'd0 :
                   (cap_eff == '0) ? 32'(key_r) :
                   do_evict ? 32'(lru_key_r) : 32'd0;
    end
    if (cmd.step) begin
      rd_idx_r <= IW'(idx_r);
      if (rd_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_val_r <= rd_val_r;
      end
      if (rd_lru && !lru_ok_r) begin
        lru_ok_r  <= 1'b1;
        lru_idx_r <= rd_idx_r;
        lru_key_r <= rd_key_r;
      end
      if (rd_pend_r && !valid_r[rd_idx_r] && !free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
    if (cmd.start) begin
      hit_r <= 1'b0; lru_ok_r <= 1'b0; free_ok_r <= 1'b0;
      hit_idx_r <= '0; lru_idx_r <= '0; free_idx_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      occ_r     <= '0;
      cap_r     <= 5'd16;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      if (cmd.start) begin
        idx_r     <= '0;
        rd_pend_r <= 1'b0;
      end else if (cmd.step) begin
        rd_pend_r <= (idx_r != CW'(ENTRIES));
        if (idx_r != CW'(ENTRIES)) idx_r <= idx_r + 1'b1;
      end
      if (cmd.commit && (hit_r || do_ins)) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == slot) rank_r[i] <= '0;
          else if (valid_r[i] && !(do_evict && IW'(i) == lru_idx_r) &&
                   (limit_all || rank_r[i] < limit))
            rank_r[i] <= rank_r[i] + 1'b1;
        end
        if (do_ins) begin
          valid_r[slot] <= 1'b1;
          if (!do_evict) occ_r <= occ_r + 1'b1;
        end
      end
      if (cmd.clear) begin
        cap_r   <= cfg_data;
        valid_r <= '0;
        occ_r   <= '0;
        for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
      end
    end
  end

  assign out_found       = found_r;
  assign out_read_value  = rval_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evkey_r;

endmodule

### rtl/core/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key/value cache top level
// Channel   | Handshake            | Payload
// in_       | in_valid / in_ready  | req_type, lookup_key, write_value
// out_      | out_valid / out_ready| found, read_value, evicted, evicted_key
// cfg_      | cfg_valid / cfg_ready| capacity (5 bits)
// After a request is taken, the key memory is scanned at one entry per cycle
// through its single read port with a registered read; the end of the scan is
// then detected, the commit step updates the store, and the result is shown.
// The next request is taken only after the result has been accepted, and a
// pending configuration write is taken ahead of it.
// Reset is synchronous; capacity resets to 16 and the store is empty.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top import lrukv_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [31:0]        in_lookup_key,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic signed [31:0] out_read_value,
  output logic               out_evicted,
  output logic [31:0]        out_evicted_key,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  lrukv_cmd_t cmd;
  lrukv_sts_t sts;

  lrukv_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cfg_valid, .cfg_ready, .sts, .cmd
  );

  lrukv_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_data, .in_req_type, .in_lookup_key,
    .in_write_value, .out_found, .out_read_value, .out_evicted, .out_evicted_key
  );

endmodule

### rtl/core/lrukv_checker.sv
// ----------------------------------------------------------------------------
// LRU key/value cache checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module lrukv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_read_value,
  input logic        out_evicted,
  input logic [31:0] out_evicted_key,
  input logic        cfg_ready
);

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready && !cfg_ready) else $error("input taken while result pending");

  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_found) &&
    $stable(out_read_value) && $stable(out_evicted_key))
    else $error("result changed while stalled");

  a_found_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_evicted)) else $error("hit with eviction");

  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == 32'd0))
    else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache_top lrukv_checker u_lrukv_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_found,
  .out_read_value, .out_evicted, .out_evicted_key, .cfg_ready
);
